FILE: hdl/udp_pdt_pkg.sv
package udp_pdt_pkg;

   // table size
   localparam int NUM_SLOTS_DEF = 8;

   // request kinds, carried on req_tuser
   localparam logic [1:0] REQ_OPEN  = 2'd0;
   localparam logic [1:0] REQ_CLOSE = 2'd1;
   localparam logic [1:0] REQ_RECV  = 2'd2;

   // response status codes, carried on rsp_tuser
   localparam logic [2:0] ST_OPENED     = 3'd0;
   localparam logic [2:0] ST_OPEN_REJ   = 3'd1;
   localparam logic [2:0] ST_CLOSED     = 3'd2;
   localparam logic [2:0] ST_CLOSE_IGN  = 3'd3;
   localparam logic [2:0] ST_DELIVERED  = 3'd4;
   localparam logic [2:0] ST_MALFORMED  = 3'd5;
   localparam logic [2:0] ST_NO_SOCKET  = 3'd6;

   localparam logic [15:0] HDR_BYTES = 16'd8;

   // bus widths
   localparam int REQ_TUSER_W = 2;
   localparam int REQ_TDATA_W = 120;
   localparam int RSP_TUSER_W = 3;
   localparam int RSP_TDATA_W = 72;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_result;
   } dp_status_type;

endpackage

FILE: hdl/udp_pdt_ctrl.sv
module udp_pdt_ctrl
   import udp_pdt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type status
);

   typedef enum logic {
      S_IDLE,
      S_EVAL
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd.capture  = req_tvalid && (state_ff == S_IDLE);
      cmd.commit   = (state_ff == S_EVAL) && out_free;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = status.has_result;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hdl/udp_pdt_dpath.sv
module udp_pdt_dpath
   import udp_pdt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam logic [8:0] SLOT_LIMIT = 9'(NUM_SLOTS);

   // bound port table
   logic [NUM_SLOTS-1:0] slot_open_ff;
   logic [15:0]          slot_port_ff [NUM_SLOTS];

   // captured request
   logic [1:0]           kind_ff;
   logic [15:0]          lport_ff;
   logic [7:0]           slot_ff;
   logic [15:0]          sport_ff;
   logic [15:0]          hlen_ff;
   logic [15:0]          avail_ff;
   logic [31:0]          saddr_ff;
   logic [NUM_SLOTS-1:0] match_vec_ff;
   logic [NUM_SLOTS-1:0] free_vec_ff;

   logic [RSP_TUSER_W-1:0] rsp_tuser_ff;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic [15:0]          key;
   logic [NUM_SLOTS-1:0] match_in;
   logic [NUM_SLOTS-1:0] match_low;
   logic [NUM_SLOTS-1:0] free_low;
   logic [SLOT_W-1:0]    match_idx;
   logic [SLOT_W-1:0]    free_idx;
   logic [31:0]          match_idx32;
   logic [31:0]          free_idx32;
   logic                 malformed;
   logic                 close_ok;
   logic                 open_ok;
   logic [2:0]           st;
   logic [2:0]           idx3;
   logic [31:0]          paddr;
   logic [15:0]          pport;
   logic [15:0]          plen;

   assign rsp_tuser = rsp_tuser_ff;
   assign rsp_tdata = rsp_tdata_ff;

   // parallel port compare against every slot
   always_comb begin
      key = (req_tuser == REQ_OPEN) ? req_tdata[15:0] : req_tdata[39:24];
      for (int s = 0; s < NUM_SLOTS; s++) begin
         match_in[s] = slot_open_ff[s] && (slot_port_ff[s] == key);
      end
   end

   // lowest set bit, then or-encode
   always_comb begin
      match_low = match_vec_ff & (~match_vec_ff + NUM_SLOTS'(1));
      free_low  = free_vec_ff & (~free_vec_ff + NUM_SLOTS'(1));
      match_idx = '0;
      free_idx  = '0;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         if (match_low[s]) match_idx = match_idx | SLOT_W'(s);
         if (free_low[s])  free_idx  = free_idx | SLOT_W'(s);
      end
      match_idx32 = 32'(match_idx);
      free_idx32  = 32'(free_idx);
   end

   always_comb begin
      malformed = (avail_ff < HDR_BYTES) || (hlen_ff < HDR_BYTES) || (hlen_ff > avail_ff);
      close_ok  = {1'b0, slot_ff} < SLOT_LIMIT;
      open_ok   = (lport_ff != 16'd0) && !(|match_vec_ff) && (|free_vec_ff);
      status.has_result = 1'b1;
      st    = ST_OPEN_REJ;
      idx3  = 3'd0;
      paddr = 32'd0;
      pport = 16'd0;
      plen  = 16'd0;
      case (kind_ff)
         REQ_OPEN: begin
            if (open_ok) begin
               st   = ST_OPENED;
               idx3 = free_idx32[2:0];
            end else begin
               st = ST_OPEN_REJ;
            end
         end
         REQ_CLOSE: begin
            st = close_ok ? ST_CLOSED : ST_CLOSE_IGN;
         end
         REQ_RECV: begin
            if (malformed) begin
               st = ST_MALFORMED;
            end else if (|match_vec_ff) begin
               st    = ST_DELIVERED;
               idx3  = match_idx32[2:0];
               paddr = saddr_ff;
               pport = sport_ff;
               plen  = hlen_ff - HDR_BYTES;
            end else begin
               st = ST_NO_SOCKET;
            end
         end
         default: begin
            status.has_result = 1'b0;
         end
      endcase
   end

   // table state
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_open_ff <= '0;
      end else if (cmd.commit) begin
         if (kind_ff == REQ_OPEN && open_ok) begin
            slot_open_ff[free_idx] <= 1'b1;
         end else if (kind_ff == REQ_CLOSE && close_ok) begin
            slot_open_ff[slot_ff[SLOT_W-1:0]] <= 1'b0;
         end
      end
   end

   // ports are only looked at while the slot is open
   always_ff @(posedge clock) begin
      if (cmd.commit && kind_ff == REQ_OPEN && open_ok) begin
         slot_port_ff[free_idx] <= lport_ff;
      end
   end

   // request capture and output register
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= req_tuser;
         lport_ff     <= req_tdata[15:0];
         slot_ff      <= req_tdata[23:16];
         sport_ff     <= req_tdata[55:40];
         hlen_ff      <= req_tdata[71:56];
         avail_ff     <= req_tdata[87:72];
         saddr_ff     <= req_tdata[119:88];
         match_vec_ff <= match_in;
         free_vec_ff  <= ~slot_open_ff;
      end
      if (cmd.commit && status.has_result) begin
         rsp_tuser_ff <= st;
         rsp_tdata_ff <= {5'd0, plen, pport, paddr, idx3};
      end
   end

endmodule

FILE: hdl/udp_port_demux_table_unit.sv
// channel   dir  handshake            tuser                 tdata
// req_      in   req_tvalid/tready    request kind (2b)     port, slot, udp header fields
// rsp_      out  rsp_tvalid/tready    status (3b)           slot index, peer, payload length
//
// in each transaction the accept cycle compares the key port
// against every slot and registers the match and free vectors, then the
// evaluate state priority-encodes them, updates the table and loads the output register
// the next request can be accepted right after, while a response still waits
// a stalled response holds the controller in its evaluate state
// synchronous reset empties the table and drops any pending response
module udp_port_demux_table_unit
   import udp_pdt_pkg::*;
#(
   parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // req_type
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   // bind_port, slot_number, dest_port, source_port, header_length,
   // bytes_available, source_address
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // slot_index, peer_address, peer_port, payload_length, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;

   // handshake sequencing and response valid
   udp_pdt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (dp_status)
   );

   // slot table, match logic and response payload
   udp_pdt_dpath #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (dp_status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: hdl/udp_pdt_checker.sv
module udp_pdt_checker
   import udp_pdt_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TUSER_W-1:0] rsp_tuser,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tuser) && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // one request in evaluation at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted during evaluation");

   // peer fields only on delivery
   a_peer_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DELIVERED |-> rsp_tdata[71:3] == '0)
      else $error("peer fields set without delivery");

   // slot index only on open success or delivery
   a_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_DELIVERED && rsp_tuser != ST_OPENED
         |-> rsp_tdata[2:0] == 3'd0)
      else $error("slot index set on a status without one");

endmodule

bind udp_port_demux_table_unit udp_pdt_checker u_chk (.*);
